@@ sv/gbj_pkg.sv @@
package gbj_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int Cells = MaxRows * MaxCols;
  localparam int IdxW = RowW + ColW;
  localparam int CntW = IdxW + 1;
  localparam int RegW = 7;
  localparam int DistW = 13;
  localparam logic [DistW-1:0] DistMax = 13'd4095;

  localparam logic [1:0] CellFree  = 2'd0;
  localparam logic [1:0] CellWall  = 2'd1;
  localparam logic [1:0] CellBoost = 2'd2;

  localparam logic [2:0] RegNumRows   = 3'd0;
  localparam logic [2:0] RegNumCols   = 3'd1;
  localparam logic [2:0] RegStartRow  = 3'd2;
  localparam logic [2:0] RegStartCol  = 3'd3;
  localparam logic [2:0] RegTargetRow = 3'd4;
  localparam logic [2:0] RegTargetCol = 3'd5;

  // Command from the load front to the search back
  typedef struct packed {
    logic       last;
    logic [1:0] code;
    logic       store;
    logic [IdxW-1:0] addr;
  } cmd_t;

  // Search geometry, 0-based
  typedef struct packed {
    logic [RowW:0] rows;
    logic [ColW:0] cols;
    logic          skip;
    logic [RowW-1:0] sr;
    logic [ColW-1:0] sc;
    logic [RowW-1:0] tr;
    logic [ColW-1:0] tc;
  } geom_t;

  function automatic logic [IdxW-1:0] cell_idx(logic [RowW-1:0] r, logic [ColW-1:0] c);
    cell_idx = {r, c};
  endfunction

endpackage

@@ sv/gbj_front.sv @@
// Load front: tracks load position and classifies each cell transfer
module gbj_front import gbj_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      cell_type_i,
  input  logic            last_cell_i,
  input  logic [RowW:0]   rows_i,
  input  logic [ColW:0]   cols_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output cmd_t            cmd_o
);

  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] used;
  logic            store;
  logic            fire;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign fire        = in_valid_i && cmd_ready_i;

  // Cells in use; anything past them is dropped until the last cell
  assign used  = CntW'(rows_i) * CntW'(cols_i);
  assign store = (pos_q < used);

  assign cmd_o.last  = last_cell_i;
  assign cmd_o.code  = cell_type_i;
  assign cmd_o.store = store;
  assign cmd_o.addr  = pos_q[IdxW-1:0];

  // Row-major load position
  always_comb begin
    pos_d = pos_q;
    if (fire) begin
      if (last_cell_i) begin
        pos_d = '0;
      end else if (store) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ sv/gbj_fifo.sv @@
// Two-entry command queue between front and back
module gbj_fifo import gbj_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  cmd_t  wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output cmd_t  rd_data_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ sv/gbj_back.sv @@
// Search back: grid store and breadth-first search sequencer
module gbj_back import gbj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  input  geom_t             geom_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [DistW-1:0]  distance_o,
  output logic              reached_o
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StClear = 9'b000000010,
    StSeed  = 9'b000000100,
    StPop   = 9'b000001000,
    StRead  = 9'b000010000,
    StGen   = 9'b000100000,
    StCheck = 9'b001000000,
    StVisit = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Memories
  logic [1:0]       grid_mem  [Cells];
  logic [DistW-1:0] dist_mem  [Cells];
  logic             vis_mem   [Cells];
  logic [IdxW-1:0]  queue_mem [Cells];

  logic [CntW-1:0]  head_q, tail_q;
  logic [IdxW-1:0]  clr_q;
  logic [IdxW-1:0]  cur_q;
  logic [DistW-1:0] nd_q;
  logic [1:0]       ccode_q;
  logic [ColW:0]    k_q;      // sweep position / direction index
  logic [1:0]       phase_q;  // boost: 0 row-down,1 row-up,2 col-right,3 col-left
  logic [IdxW-1:0]  nb_q;
  logic [1:0]       grid_rd_q;
  logic             vis_rd_q;
  logic [IdxW-1:0]  qrd_q;
  logic [DistW-1:0] drd_q;
  logic             ok_q;
  logic [DistW-1:0] res_dist_q;
  logic             res_reach_q, res_valid_q;
  logic [1:0]       rd_cnt_q;
  logic             last_q;

  logic [RowW-1:0] cr;
  logic [ColW-1:0] cc;
  assign cr = cur_q[IdxW-1:ColW];
  assign cc = cur_q[ColW-1:0];

  assign cmd_ready_o = (state_q == StIdle) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign distance_o  = res_dist_q;
  assign reached_o   = res_reach_q;

  // Grid store is row-major over the columns in use
  function automatic logic [IdxW-1:0] grid_addr(logic [RowW-1:0] r, logic [ColW-1:0] c,
                                                logic [ColW:0] n);
    logic [CntW-1:0] a;
    a = CntW'(r) * CntW'(n) + CntW'(c);
    return a[IdxW-1:0];
  endfunction

  // Neighbor generation for current candidate
  logic            gen_ok;
  logic [IdxW-1:0] gen_idx;
  logic            gen_end;
  logic [RowW:0]   nr;
  logic [ColW:0]   nc;
  always_comb begin
    gen_ok  = 1'b0;
    gen_idx = '0;
    gen_end = 1'b0;
    nr      = {1'b0, cr};
    nc      = {1'b0, cc};
    if (ccode_q == CellBoost) begin
      // k_q counts steps from 1 in each sweep direction
      unique case (phase_q)
        2'd0: nr = {1'b0, cr} + k_q[RowW:0];
        2'd1: nr = {1'b0, cr} - k_q[RowW:0];
        2'd2: nc = {1'b0, cc} + k_q;
        default: nc = {1'b0, cc} - k_q;
      endcase
      gen_ok = (nr < geom_i.rows) && (nc < geom_i.cols) && !nr[RowW] && !nc[ColW];
      gen_end = !gen_ok && (phase_q == 2'd3);
    end else begin
      unique case (k_q[1:0])
        2'd0: nr = {1'b0, cr} + 1'b1;
        2'd1: nr = {1'b0, cr} - 1'b1;
        2'd2: nc = {1'b0, cc} + 1'b1;
        default: nc = {1'b0, cc} - 1'b1;
      endcase
      gen_ok  = (nr < geom_i.rows) && (nc < geom_i.cols) && !nr[RowW] && !nc[ColW];
      gen_end = (k_q[1:0] == 2'd3);
    end
    gen_idx = cell_idx(nr[RowW-1:0], nc[ColW-1:0]);
  end

  logic [IdxW-1:0] grid_raddr;
  assign grid_raddr = (state_q == StGen) ?
                      grid_addr(nr[RowW-1:0], nc[ColW-1:0], geom_i.cols) :
                      grid_addr(cr, cc, geom_i.cols);

  logic do_visit, do_clear, do_seed, hit;
  logic [IdxW-1:0] wr_idx;
  assign do_seed  = (state_q == StSeed);
  assign do_visit = (state_q == StVisit) && ok_q && !vis_rd_q &&
                    ((ccode_q == CellBoost) || (grid_rd_q != CellWall));
  assign do_clear = (state_q == StClear);
  assign wr_idx   = do_seed ? cell_idx(geom_i.sr, geom_i.sc) : nb_q;
  assign hit      = (qrd_q == cell_idx(geom_i.tr, geom_i.tc));

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o && cmd_i.store) grid_mem[cmd_i.addr] <= cmd_i.code;
    grid_rd_q <= grid_mem[grid_raddr];
    if (do_clear) vis_mem[clr_q] <= 1'b0;
    else if (do_seed || do_visit) vis_mem[wr_idx] <= 1'b1;
    vis_rd_q <= vis_mem[gen_idx];
    if (do_seed || do_visit) begin
      dist_mem[wr_idx] <= do_seed ? '0 : nd_q;
      queue_mem[tail_q[IdxW-1:0]] <= wr_idx;
    end
    drd_q <= dist_mem[qrd_q];
    qrd_q <= queue_mem[head_q[IdxW-1:0]];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (cmd_valid_i && cmd_ready_o && cmd_i.last)
                 state_d = geom_i.skip ? StDone : StClear;
      StClear: if (clr_q == IdxW'(Cells - 1)) state_d = StSeed;
      StSeed:  state_d = StPop;
      StPop: begin
        // queue read, then distance read, then take the entry
        if (head_q == tail_q) state_d = StDone;
        else if (rd_cnt_q == 2'd2) state_d = hit ? StDone : StRead;
      end
      StRead:  state_d = StCheck;
      StCheck: state_d = StGen;
      StGen:   state_d = StVisit;
      StVisit: state_d = last_q ? StPop : StGen;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      res_reach_q <= 1'b0;
      res_dist_q  <= '0;
      k_q         <= '0;
      phase_q     <= '0;
      rd_cnt_q    <= '0;
      last_q      <= 1'b0;
      ok_q        <= 1'b0;
      cur_q       <= '0;
      nd_q        <= '0;
      ccode_q     <= '0;
      nb_q        <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          clr_q <= '0;
          if (cmd_valid_i && cmd_ready_o && cmd_i.last) begin
            head_q <= '0;
            tail_q <= '0;
            res_reach_q <= 1'b0;
            res_dist_q  <= '1;
          end
        end
        StClear: begin
          clr_q <= clr_q + 1'b1;
        end
        StSeed: begin
          tail_q   <= tail_q + 1'b1;
          rd_cnt_q <= '0;
        end
        StPop: begin
          if (head_q != tail_q) begin
            if (rd_cnt_q == 2'd2) begin
              rd_cnt_q <= '0;
              cur_q    <= qrd_q;
              nd_q     <= drd_q + 1'b1;
              head_q   <= head_q + 1'b1;
              if (hit) begin
                res_reach_q <= 1'b1;
                res_dist_q  <= (drd_q > DistMax) ? DistMax : drd_q;
              end
            end else begin
              rd_cnt_q <= rd_cnt_q + 1'b1;
            end
          end
        end
        StRead: begin
          // grid code of current cell arrives next cycle
          last_q  <= 1'b0;
          k_q     <= '0;
          phase_q <= '0;
        end
        StCheck: begin
          ccode_q <= grid_rd_q;
          k_q     <= (grid_rd_q == CellBoost) ? {{ColW{1'b0}}, 1'b1} : '0;
        end
        StGen: begin
          ok_q   <= gen_ok;
          nb_q   <= gen_idx;
          last_q <= gen_end;
          if (ccode_q == CellBoost) begin
            if (gen_ok) begin
              k_q <= k_q + 1'b1;
            end else if (phase_q != 2'd3) begin
              phase_q <= phase_q + 1'b1;
              k_q     <= {{ColW{1'b0}}, 1'b1};
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        StVisit: begin
          if (do_visit && (tail_q != CntW'(Cells))) tail_q <= tail_q + 1'b1;
        end
        StDone: begin
          res_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sv/grid_bfs_with_jump_cells.sv @@
// Grid breadth-first search with boost cells. Cells are loaded one per transfer
// at one per cycle when input is not stalled, in row-major order; the transfer
// with last_cell_i set starts a search. The search first clears the visited
// map, then pops the queue and checks each neighbor candidate of the popped
// cell (4 for a normal cell, up to rows+cols+2 for a boost cell), limited by
// the single read port of each memory. The result appears after the search;
// while it runs or waits, the two-entry command queue takes up to two more
// cells and then input stalls. Registers: 0 num_rows, 1 num_cols, 2 start_row,
// 3 start_col, 4 target_row, 5 target_col (sizes saturate to 1..64).
module grid_bfs_with_jump_cells import gbj_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              cell_type_i,
  input  logic                    last_cell_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [RegW-1:0]         cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DistW-1:0] distance_o,
  output logic                    reached_o
);

  logic [RegW-1:0] rows_q, cols_q, srow_q, scol_q, trow_q, tcol_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RegW'(MaxRows);
      cols_q <= RegW'(MaxCols);
      srow_q <= RegW'(1);
      scol_q <= RegW'(1);
      trow_q <= RegW'(1);
      tcol_q <= RegW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegNumRows:   rows_q <= cfg_data_i;
        RegNumCols:   cols_q <= cfg_data_i;
        RegStartRow:  srow_q <= cfg_data_i;
        RegStartCol:  scol_q <= cfg_data_i;
        RegTargetRow: trow_q <= cfg_data_i;
        RegTargetCol: tcol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturated geometry
  geom_t geom;
  logic [RegW-1:0] rs, cs;
  always_comb begin
    rs = (rows_q == '0) ? RegW'(1) : (rows_q > RegW'(MaxRows)) ? RegW'(MaxRows) : rows_q;
    cs = (cols_q == '0) ? RegW'(1) : (cols_q > RegW'(MaxCols)) ? RegW'(MaxCols) : cols_q;
    geom.rows = rs[RowW:0];
    geom.cols = cs[ColW:0];
    geom.skip = (srow_q == '0) || (srow_q > rs) || (scol_q == '0) || (scol_q > cs) ||
                (trow_q == '0) || (trow_q > rs) || (tcol_q == '0) || (tcol_q > cs);
    geom.sr = RowW'(srow_q - 1'b1);
    geom.sc = ColW'(scol_q - 1'b1);
    geom.tr = RowW'(trow_q - 1'b1);
    geom.tc = ColW'(tcol_q - 1'b1);
  end

  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready;

  gbj_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cell_type_i, .last_cell_i,
    .rows_i(geom.rows), .cols_i(geom.cols),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  gbj_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd)
  );

  logic [DistW-1:0] dist_raw;
  gbj_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .geom_i(geom), .res_valid_o(out_valid_o), .res_ready_i(out_ready_i),
    .distance_o(dist_raw), .reached_o
  );
  assign distance_o = signed'(dist_raw);

  // A miss always reports -1
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reached_o |-> distance_o == -13'sd1) else $error("bad miss");
  // A result holds until transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o))
    else $error("result dropped");
  // A hit never carries a negative distance
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reached_o |-> !distance_o[DistW-1]) else $error("bad hit");

endmodule
